@@ hw/rtl/stq_pkg.sv @@
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants for the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int MAX_FIRES  = 16;
  localparam int RESULT_CAP = 16;
  localparam int FIRE_LIMIT = (MAX_FIRES < RESULT_CAP) ? MAX_FIRES : RESULT_CAP;

  localparam int ID_W   = 4;
  localparam int TIME_W = 64;
  localparam int IDX_W  = $clog2(NUM_TIMERS);
  localparam int CNT_W  = $clog2(NUM_TIMERS + 1);
  localparam int FIRE_W = $clog2(FIRE_LIMIT + 1);

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [FIRE_W-1:0] fire_t;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_START    = 2'd1,
    OP_STOP     = 2'd2,
    OP_STOP_ALL = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UNLINK,
    S_LINK_RD,
    S_LINK_CMP,
    S_TCHK,
    S_TCMP,
    S_TADD,
    S_TEND,
    S_DONE
  } state_t;

endpackage

@@ hw/rtl/stq_cmd_if.sv @@
// ----------------------------------------------------------------------------
// stq_cmd_if
// Command channel: ticks, timer starts and stops.
// ----------------------------------------------------------------------------
interface stq_cmd_if;
  import stq_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] op;
  id_t        timer_id;
  time_t      expires_at;
  logic       periodic;
  time_t      period;
  time_t      now_time;

  modport source (output valid, op, timer_id, expires_at, periodic, period, now_time,
                  input ready);
  modport sink   (input valid, op, timer_id, expires_at, periodic, period, now_time,
                  output ready);
endinterface

@@ hw/rtl/stq_res_if.sv @@
// ----------------------------------------------------------------------------
// stq_res_if
// Result channel: one beat per firing or per command.
// ----------------------------------------------------------------------------
interface stq_res_if;
  import stq_pkg::*;

  logic valid;
  logic ready;
  logic fired;
  id_t  fired_id;
  logic last;

  modport source (output valid, fired, fired_id, last, input ready);
  modport sink   (input valid, fired, fired_id, last, output ready);
endinterface

@@ hw/rtl/stq_ram.sv @@
// ----------------------------------------------------------------------------
// stq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ hw/rtl/stq_alu.sv @@
// ----------------------------------------------------------------------------
// stq_alu
// Shared 64-bit adder/subtractor; carry out gives both overflow and compare.
// ----------------------------------------------------------------------------
module stq_alu (
  input  stq_pkg::time_t a,
  input  stq_pkg::time_t b,
  input  logic           sub,
  output stq_pkg::time_t result,
  output logic           carry
);
  import stq_pkg::*;

  time_t b_op;

  // sub: a - b, carry set means a >= b
  assign b_op = sub ? ~b : b;
  assign {carry, result} = {1'b0, a} + {1'b0, b_op} + {{TIME_W{1'b0}}, sub};
endmodule

@@ hw/rtl/sorted_timer_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Timer list kept in expiry order, driven by a sequencer around one shared
// adder/comparator and two expiry/period RAMs.
// ----------------------------------------------------------------------------
// A stop-all clears the list when taken. A stop scans the list for its entry; a start
//   does the same scan on a restart to find the old position, then walks the list to
//   insert, each compare waiting on a registered RAM read.
// A tick checks the head against now for each firing and re-inserts each periodic one.
// One item at a time; a new item is taken while the last result beat waits.
// Reset (synchronous, rst high) empties the list and disarms every timer.
// ----------------------------------------------------------------------------
module sorted_timer_queue (
  input logic       clk,
  input logic       rst,
  stq_cmd_if.sink   cmd,
  stq_res_if.source res
);
  import stq_pkg::*;

  state_t state, state_next;

  op_t    op_r;
  id_t    cur_id;
  time_t  key;
  time_t  now_r;
  cnt_t   pos;
  cnt_t   count;
  fire_t  n_fire;
  logic   pend;
  id_t    pend_id;
  id_t    order [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] armed;
  logic [NUM_TIMERS-1:0] periodic_r;

  // RAM and ALU hookup
  logic   rd_en;
  idx_t   rd_addr;
  logic   exp_we;
  idx_t   exp_waddr;
  time_t  exp_wdata;
  time_t  exp_rdata;
  time_t  per_rdata;
  time_t  alu_a, alu_b, alu_res;
  logic   alu_sub, alu_carry;
  time_t  sat_sum;

  // sequencer outputs
  logic   accept;
  logic   id_ok;
  logic   slot_free;
  logic   push, push_fired, push_last;
  id_t    push_id;
  logic   ord_rm, ord_ins;
  cnt_t   rm_pos;
  logic   scan_end, hit, lt, ge, more;

  idx_t   pos_idx, cur_idx;

  assign pos_idx   = pos[IDX_W-1:0];
  assign cur_idx   = cur_id[IDX_W-1:0];
  assign accept    = cmd.valid && cmd.ready;
  assign id_ok     = int'(cmd.timer_id) < NUM_TIMERS;
  assign slot_free = !res.valid || res.ready;
  assign scan_end  = pos >= count;
  assign hit       = order[pos_idx] == cur_id;
  assign lt        = !alu_carry;
  assign ge        = alu_carry;
  assign more      = (n_fire < FIRE_W'(FIRE_LIMIT)) && (count != '0);
  assign sat_sum   = alu_carry ? '1 : alu_res;

  stq_ram #(.WIDTH(TIME_W), .DEPTH(NUM_TIMERS)) u_exp_ram (
    .clk   (clk),
    .we    (exp_we),
    .waddr (exp_waddr),
    .wdata (exp_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (exp_rdata)
  );

  stq_ram #(.WIDTH(TIME_W), .DEPTH(NUM_TIMERS)) u_per_ram (
    .clk   (clk),
    .we    (accept && op_t'(cmd.op) == OP_START && id_ok),
    .waddr (cmd.timer_id[IDX_W-1:0]),
    .wdata (cmd.period),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (per_rdata)
  );

  stq_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .result (alu_res),
    .carry  (alu_carry)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          case (op_t'(cmd.op))
            OP_TICK:  state_next = S_TCHK;
            OP_START: state_next = !id_ok ? S_DONE :
                                   armed[cmd.timer_id[IDX_W-1:0]] ? S_UNLINK : S_LINK_RD;
            OP_STOP:  state_next = (id_ok && armed[cmd.timer_id[IDX_W-1:0]]) ?
                                   S_UNLINK : S_DONE;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_UNLINK: begin
        if (scan_end || hit) begin
          state_next = (op_r == OP_START) ? S_LINK_RD : S_DONE;
        end
      end
      S_LINK_RD: begin
        if (scan_end) begin
          state_next = (op_r == OP_TICK) ? S_TCHK : S_DONE;
        end else begin
          state_next = S_LINK_CMP;
        end
      end
      S_LINK_CMP: begin
        if (lt) begin
          state_next = S_LINK_RD;
        end else begin
          state_next = (op_r == OP_TICK) ? S_TCHK : S_DONE;
        end
      end
      S_TCHK:  state_next = more ? S_TCMP : S_TEND;
      S_TCMP: begin
        if (!ge) begin
          state_next = S_TEND;
        end else if (!pend || slot_free) begin
          state_next = periodic_r[cur_idx] ? S_TADD : S_TCHK;
        end
      end
      S_TADD:  state_next = S_LINK_RD;
      S_TEND:  state_next = slot_free ? S_IDLE : S_TEND;
      S_DONE:  state_next = slot_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd.ready  = state == S_IDLE;
    rd_en      = 1'b0;
    rd_addr    = order[pos_idx][IDX_W-1:0];
    exp_we     = 1'b0;
    exp_waddr  = cmd.timer_id[IDX_W-1:0];
    exp_wdata  = cmd.expires_at;
    alu_a      = exp_rdata;
    alu_b      = key;
    alu_sub    = 1'b1;
    push       = 1'b0;
    push_fired = 1'b0;
    push_id    = '0;
    push_last  = 1'b1;
    ord_rm     = 1'b0;
    ord_ins    = 1'b0;
    rm_pos     = pos;
    case (state)
      S_IDLE: begin
        exp_we = accept && op_t'(cmd.op) == OP_START && id_ok;
      end
      S_UNLINK: begin
        ord_rm = !scan_end && hit;
      end
      S_LINK_RD: begin
        rd_en   = !scan_end;
        ord_ins = scan_end;
      end
      S_LINK_CMP: begin
        ord_ins = !lt;
      end
      S_TCHK: begin
        rd_en   = more;
        rd_addr = order[0][IDX_W-1:0];
      end
      S_TCMP: begin
        alu_a = now_r;
        alu_b = exp_rdata;
        if (ge && (!pend || slot_free)) begin
          ord_rm     = 1'b1;
          rm_pos     = '0;
          push       = pend;
          push_fired = 1'b1;
          push_id    = pend_id;
          push_last  = 1'b0;
        end
      end
      S_TADD: begin
        alu_a     = exp_rdata;
        alu_b     = per_rdata;
        alu_sub   = 1'b0;
        exp_we    = 1'b1;
        exp_waddr = cur_idx;
        exp_wdata = sat_sum;
      end
      S_TEND: begin
        push       = slot_free;
        push_fired = pend;
        push_id    = pend ? pend_id : '0;
      end
      S_DONE: begin
        push = slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control and list state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      armed <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_r   <= op_t'(cmd.op);
            cur_id <= cmd.timer_id;
            key    <= cmd.expires_at;
            now_r  <= cmd.now_time;
            pos    <= '0;
            n_fire <= '0;
            pend   <= 1'b0;
            if (op_t'(cmd.op) == OP_START && id_ok) begin
              periodic_r[cmd.timer_id[IDX_W-1:0]] <= cmd.periodic;
            end
            if (op_t'(cmd.op) == OP_STOP_ALL) begin
              armed <= '0;
              count <= '0;
            end
          end
        end
        S_UNLINK: begin
          if (scan_end || hit) begin
            pos <= '0;
          end else begin
            pos <= pos + 1'b1;
          end
          if (ord_rm) begin
            count <= count - 1'b1;
            if (op_r == OP_STOP) begin
              armed[cur_idx] <= 1'b0;
            end
          end
        end
        S_LINK_RD, S_LINK_CMP: begin
          if (ord_ins) begin
            count          <= count + 1'b1;
            armed[cur_idx] <= 1'b1;
          end else if (state == S_LINK_CMP) begin
            pos <= pos + 1'b1;
          end
        end
        S_TCHK: begin
          cur_id <= order[0];
        end
        S_TCMP: begin
          if (ord_rm) begin
            count   <= count - 1'b1;
            n_fire  <= n_fire + 1'b1;
            pend    <= 1'b1;
            pend_id <= cur_id;
            if (!periodic_r[cur_idx]) begin
              armed[cur_idx] <= 1'b0;
            end
          end
        end
        S_TADD: begin
          key <= sat_sum;
          pos <= '0;
        end
        default: ;
      endcase
    end
  end

  // order list: ids of armed timers, earliest expiry first
  always_ff @(posedge clk) begin
    if (ord_rm) begin
      for (int k = 0; k < NUM_TIMERS - 1; k++) begin
        if (k >= int'(rm_pos)) begin
          order[k] <= order[k+1];
        end
      end
    end
    if (ord_ins) begin
      for (int k = 1; k < NUM_TIMERS; k++) begin
        if (k > int'(pos)) begin
          order[k] <= order[k-1];
        end
      end
      order[pos_idx] <= cur_id;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (push) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res.fired    <= push_fired;
      res.fired_id <= push_id;
      res.last     <= push_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NUM_TIMERS))
    else $error("queue count beyond timer count");

  a_armed_match: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> $countones(armed) == int'(count))
    else $error("armed flags disagree with queue count");

  a_idle_beat: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.fired |-> res.last && res.fired_id == '0)
    else $error("non-firing beat must be a lone last beat");

  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !cmd.ready)
    else $error("second item taken while one is in progress");

endmodule

@@ tb/sorted_timer_queue_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_timer_queue_tb
// Drives timer starts, stops, stop-alls and ticks into the timer queue. A
// scoreboard model of the expiry-ordered list predicts each result beat, or a
// table row gives it, and the beats that come out are checked in order. A short
// table of corner cases runs first, then constrained-by-hand random traffic
// with random stalls on both channels.
// ----------------------------------------------------------------------------
module sorted_timer_queue_tb;
  import stq_pkg::*;

  localparam int    RANDOM_ITEMS   = 245;
  localparam int    CALM_ITEMS     = 40;
  localparam int    RX_HOLD_CYCLES = 400;
  localparam int    TAIL_CYCLES    = 700;
  localparam int    CYCLE_LIMIT    = 1200000;
  localparam time_t T_MAX          = '1;
  localparam time_t T_ALT_A        = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam time_t T_ALT_5        = 64'h5555_5555_5555_5555;

  typedef struct packed {
    logic fired;
    id_t  fired_id;
    logic last;
  } beat_t;

  localparam beat_t QUIET_BEAT    = 6'b0_0000_1;
  localparam beat_t TIMER0_FIRES  = 6'b1_0000_1;

  typedef struct {
    op_t   op;
    id_t   id;
    time_t at;
    logic  pf;
    time_t per;
    time_t now;
    bit    typed;
    beat_t want;
  } cmd_item_t;

  logic clk;
  logic rst;

  stq_cmd_if cmd ();
  stq_res_if res ();

  sorted_timer_queue dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // scoreboard copy of the timer list
  time_t due_at     [NUM_TIMERS];
  time_t reload     [NUM_TIMERS];
  logic  repeat_on  [NUM_TIMERS];
  logic  armed      [NUM_TIMERS];
  id_t   slot_order [NUM_TIMERS];
  int    live_count;

  beat_t step_beats [$];
  beat_t beats_due  [$];
  cmd_item_t plan   [$];

  logic  typed_on;
  beat_t typed_beat;
  bit    calm;
  bit    tx_jitter;
  bit    rx_jitter;
  bit    rx_hold_go;
  int    mismatches;
  int unsigned cycles_run;
  time_t sim_clock_us;

  initial begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      due_at[i]     = '0;
      reload[i]     = '0;
      repeat_on[i]  = 1'b0;
      armed[i]      = 1'b0;
      slot_order[i] = '0;
    end
    live_count   = 0;
    mismatches   = 0;
    cycles_run   = 0;
    calm         = 1'b0;
    tx_jitter    = 1'b1;
    rx_jitter    = 1'b1;
    rx_hold_go   = 1'b0;
    sim_clock_us = 64'd1000;
  end

  function automatic void drop_from_order(input id_t id);
    int pos;
    pos = 0;
    while (pos < live_count && slot_order[pos] != id) pos++;
    if (pos < live_count) begin
      while (pos + 1 < live_count) begin
        slot_order[pos] = slot_order[pos+1];
        pos++;
      end
      live_count--;
    end
  endfunction

  // goes ahead of every entry with an equal expiry
  function automatic void insert_in_order(input id_t id);
    int pos;
    int k;
    if (live_count >= NUM_TIMERS) return;
    pos = 0;
    while (pos < live_count && due_at[slot_order[pos]] < due_at[id]) pos++;
    for (k = live_count; k > pos; k--) slot_order[k] = slot_order[k-1];
    slot_order[pos] = id;
    live_count++;
  endfunction

  function automatic void run_timer_step(input op_t op, input id_t id, input time_t at,
                                         input logic pf, input time_t per, input time_t now);
    int    n;
    id_t   t;
    time_t e;
    time_t p;
    beat_t held;
    step_beats.delete();
    n    = 0;
    held = QUIET_BEAT;
    case (op)
      OP_TICK: begin
        while (n < FIRE_LIMIT && live_count > 0 && now >= due_at[slot_order[0]]) begin
          t = slot_order[0];
          drop_from_order(t);
          if (repeat_on[t]) begin
            e = due_at[t];
            p = reload[t];
            due_at[t] = (e > T_MAX - p) ? T_MAX : e + p;
            insert_in_order(t);
          end else begin
            armed[t] = 1'b0;
          end
          if (n > 0) step_beats.push_back(held);
          held = '{fired: 1'b1, fired_id: t, last: 1'b0};
          n++;
        end
        held.last = 1'b1;
        step_beats.push_back(held);
      end
      OP_START: begin
        if (id < NUM_TIMERS) begin
          if (armed[id]) drop_from_order(id);
          due_at[id]    = at;
          repeat_on[id] = pf;
          reload[id]    = per;
          insert_in_order(id);
          armed[id]     = 1'b1;
        end
        step_beats.push_back(QUIET_BEAT);
      end
      OP_STOP: begin
        if (id < NUM_TIMERS && armed[id]) begin
          drop_from_order(id);
          armed[id] = 1'b0;
        end
        step_beats.push_back(QUIET_BEAT);
      end
      default: begin
        for (int i = 0; i < NUM_TIMERS; i++) armed[i] = 1'b0;
        live_count = 0;
        step_beats.push_back(QUIET_BEAT);
      end
    endcase
  endfunction

  function automatic void add_row(input op_t op, input id_t id, input time_t at, input logic pf,
                                  input time_t per, input time_t now, input bit typed,
                                  input beat_t want);
    cmd_item_t it;
    it.op    = op;
    it.id    = id;
    it.at    = at;
    it.pf    = pf;
    it.per   = per;
    it.now   = now;
    it.typed = typed;
    it.want  = want;
    plan.push_back(it);
  endfunction

  function automatic time_t rand_time();
    return {$urandom, $urandom};
  endfunction

  // mostly near-term expiries and advancing ticks, with the odd wild value
  function automatic cmd_item_t rand_item();
    cmd_item_t it;
    int r;
    int k;
    it.id    = id_t'($urandom_range(0, NUM_TIMERS - 1));
    it.at    = rand_time();
    it.pf    = logic'($urandom_range(0, 1));
    it.per   = rand_time();
    it.now   = rand_time();
    it.typed = 1'b0;
    it.want  = QUIET_BEAT;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      it.op = OP_START;
      k = $urandom_range(0, 9);
      if (k < 7)       it.at = sim_clock_us + $urandom_range(0, 400);
      else if (k == 8) it.at = T_MAX;
      else if (k == 9) it.at = sim_clock_us;
      k = $urandom_range(0, 19);
      if (k < 16)       it.per = time_t'($urandom_range(1, 150));
      else if (k == 16) it.per = '0;
      else if (k == 17) it.per = T_MAX;
    end else if (r < 75) begin
      it.op = OP_TICK;
      if ($urandom_range(0, 11) != 0) begin
        sim_clock_us = sim_clock_us + $urandom_range(0, 120);
        it.now = sim_clock_us;
      end
    end else if (r < 95) begin
      it.op = OP_STOP;
    end else begin
      it.op = OP_STOP_ALL;
    end
    return it;
  endfunction

  task automatic hold_input(input int n);
    @(negedge clk);
    cmd.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drive_item(input cmd_item_t it);
    @(negedge clk);
    cmd.valid      <= 1'b1;
    cmd.op         <= it.op;
    cmd.timer_id   <= it.id;
    cmd.expires_at <= it.at;
    cmd.periodic   <= it.pf;
    cmd.period     <= it.per;
    cmd.now_time   <= it.now;
    typed_on       <= it.typed;
    typed_beat     <= it.want;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (!calm && tx_jitter && $urandom_range(0, 3) == 0) hold_input($urandom_range(1, 6));
    if ($urandom_range(0, 24) == 0) tx_jitter = ~tx_jitter;
  endtask

  // stimulus
  initial begin
    rst            = 1'b1;
    cmd.valid      = 1'b0;
    cmd.op         = OP_TICK;
    cmd.timer_id   = '0;
    cmd.expires_at = '0;
    cmd.periodic   = 1'b0;
    cmd.period     = '0;
    cmd.now_time   = '0;
    typed_on       = 1'b0;
    typed_beat     = QUIET_BEAT;

    // empty list, both time extremes
    add_row(OP_TICK,     4'd0,  '0,    1'b0, '0,    '0,    1'b1, QUIET_BEAT);
    add_row(OP_TICK,     4'd15, T_MAX, 1'b1, T_MAX, T_MAX, 1'b1, QUIET_BEAT);
    add_row(OP_STOP,     4'd5,  '0,    1'b0, '0,    '0,    1'b1, QUIET_BEAT);
    add_row(OP_START,    4'd0,  '0,    1'b0, '0,    T_MAX, 1'b1, QUIET_BEAT);
    add_row(OP_START,    4'd15, T_MAX, 1'b1, T_MAX, '0,    1'b1, QUIET_BEAT);
    // zero period, then an equal expiry that must queue ahead of it
    add_row(OP_START,    4'd3,  64'd100, 1'b1, '0, '0,     1'b1, QUIET_BEAT);
    add_row(OP_START,    4'd4,  64'd100, 1'b0, '0, '0,     1'b1, QUIET_BEAT);
    add_row(OP_TICK,     4'd0,  '0,    1'b0, '0,    '0,    1'b1, TIMER0_FIRES);
    add_row(OP_TICK,     4'd0,  '0,    1'b0, '0,    64'd100, 1'b0, QUIET_BEAT);
    add_row(OP_STOP,     4'd3,  '0,    1'b0, '0,    '0,    1'b1, QUIET_BEAT);
    // restart of an armed timer
    add_row(OP_START,    4'd7,  64'd50,  1'b1, 64'd1, '0,  1'b1, QUIET_BEAT);
    add_row(OP_START,    4'd7,  64'd200, 1'b0, '0,    '0,  1'b1, QUIET_BEAT);
    add_row(OP_TICK,     4'd0,  '0,    1'b0, '0,    64'd199, 1'b0, QUIET_BEAT);
    // saturated re-arm keeps firing up to the limit
    add_row(OP_TICK,     4'd0,  '0,    1'b0, '0,    T_MAX, 1'b0, QUIET_BEAT);
    add_row(OP_STOP_ALL, 4'd9,  T_ALT_A, 1'b1, T_ALT_5, T_ALT_A, 1'b1, QUIET_BEAT);
    add_row(OP_TICK,     4'd0,  '0,    1'b0, '0,    T_MAX, 1'b1, QUIET_BEAT);
    add_row(OP_START,    4'd9,  64'd5, 1'b1, 64'd10, '0,   1'b1, QUIET_BEAT);
    add_row(OP_START,    4'd2,  64'd5, 1'b0, '0,     '0,   1'b1, QUIET_BEAT);
    add_row(OP_TICK,     4'd0,  '0,    1'b0, '0,    64'd1000, 1'b0, QUIET_BEAT);
    // junk in the fields that a tick or stop does not use
    add_row(OP_TICK,     4'd11, T_ALT_5, 1'b1, T_ALT_A, 64'd1000, 1'b0, QUIET_BEAT);
    add_row(OP_STOP,     4'd9,  T_ALT_A, 1'b1, T_ALT_5, T_ALT_5, 1'b1, QUIET_BEAT);
    add_row(OP_STOP,     4'd9,  T_MAX, 1'b1, T_MAX,  T_MAX, 1'b1, QUIET_BEAT);
    add_row(OP_START,    4'd6,  T_ALT_A, 1'b1, T_ALT_5, '0, 1'b1, QUIET_BEAT);
    add_row(OP_TICK,     4'd0,  '0,    1'b0, '0,    T_ALT_5, 1'b0, QUIET_BEAT);
    add_row(OP_STOP_ALL, 4'd0,  '0,    1'b0, '0,    '0,    1'b1, QUIET_BEAT);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      maybe_gap();
      drive_item(plan[i]);
    end

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (k == 90) rx_hold_go = 1'b1;
      if (k == 170) begin
        hold_input(1);
        while (beats_due.size() != 0) @(negedge clk);
      end
      maybe_gap();
      drive_item(rand_item());
    end

    hold_input(1);
    while (beats_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("sorted_timer_queue: match");
    end else begin
      $display("sorted_timer_queue: mismatch");
    end
    $finish;
  end

  // result side back-pressure
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_go) begin
        rx_hold_go = 1'b0;
        res.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end else if (!calm && rx_jitter && $urandom_range(0, 4) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        res.ready <= 1'b1;
      end
      if ($urandom_range(0, 63) == 0) rx_jitter = ~rx_jitter;
    end
  end

  // scoreboard: predict on each accepted command beat, check each result beat
  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    cycles_run++;
    if (cycles_run > CYCLE_LIMIT) begin
      $display("sorted_timer_queue: mismatch");
      $finish;
    end else if (!rst) begin
      if (cmd.valid && cmd.ready) begin
        run_timer_step(op_t'(cmd.op), cmd.timer_id, cmd.expires_at, cmd.periodic,
                       cmd.period, cmd.now_time);
        if (typed_on) begin
          beats_due.push_back(typed_beat);
        end else begin
          foreach (step_beats[i]) beats_due.push_back(step_beats[i]);
        end
      end
      if (res.valid && res.ready) begin
        got = '{fired: res.fired, fired_id: res.fired_id, last: res.last};
        if (beats_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat fired=%0b id=%0d last=%0b", $time,
                   got.fired, got.fired_id, got.last);
        end else begin
          want = beats_due.pop_front();
          if (got.fired !== want.fired || got.fired_id !== want.fired_id ||
              got.last !== want.last) begin
            mismatches++;
            $display("%0t: expected fired=%0b id=%0d last=%0b, got fired=%0b id=%0d last=%0b",
                     $time, want.fired, want.fired_id, want.last,
                     got.fired, got.fired_id, got.last);
          end
        end
      end
    end
  end

endmodule
